[hdl/ifr_pkg.sv]
// shared types, constants and helpers for the integer to ascii formatter
package ifr_pkg;

	localparam int MAG_W      = 64;
	localparam int HALF_W     = MAG_W / 2;
	localparam int RADIX_W    = 5;
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 8;
	localparam int COUNT_W    = 6;
	localparam int CMD_W      = 2;
	localparam int PFX_W      = 2;
	localparam int NPRE_W     = 2;
	localparam int LG2_W      = 2;
	localparam int MAX_DIGITS = 32;
	localparam int DIG_IDX_W  = 5;
	localparam int NDIG_W     = 6;
	localparam int CHUNK_BITS = 8;
	localparam int CHUNK_CNT_W = 3;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = 2;
	localparam int S_TDATA_W  = 80;
	localparam int M_TDATA_W  = 16;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;

	typedef enum logic [CMD_W-1:0] {
		CMD_SIGNED   = 2'd0,
		CMD_UNSIGNED = 2'd1,
		CMD_ADDR     = 2'd2
	} cmd_t;

	typedef enum logic [PFX_W-1:0] {
		PFX_NONE  = 2'd0,
		PFX_LOWER = 2'd1,
		PFX_UPPER = 2'd2
	} pfx_t;

	// one classified number, as queued between front and back
	typedef struct packed {
		logic [MAG_W-1:0]   mag;
		logic [RADIX_W-1:0] radix;
		logic               pow2;
		logic [LG2_W-1:0]   lg2;
		logic               upper;
		logic [NPRE_W-1:0]  npre;
		logic [CHAR_W-1:0]  pre0;
		logic [CHAR_W-1:0]  pre1;
	} job_t;

	// one digit from the extraction unit, least significant first
	typedef struct packed {
		logic               valid;
		logic               last;
		logic [DIGIT_W-1:0] value;
	} digit_t;

	function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d, logic upper);
		logic [CHAR_W-1:0] base;
		base = upper ? CH_A_UP : CH_A_LO;
		if (d < 4'd10)
			return CH_ZERO + {4'd0, d};
		return base + {4'd0, d} - 8'd10;
	endfunction

endpackage

[hdl/integer_to_ascii_radix_formatter_core.sv]
// top level of the integer to ascii radix formatter
//
// one number enters per word on the s_axis side; its text leaves on the m_axis side
// as one character per word, most significant digit first, with tlast on the final
// character and a running character count beside each character
// modes: signed 32-bit with '-', '+' or ' ' in front; unsigned 32-bit with optional
// 0x or 0X prefix; address mode writes 0x and 64-bit lowercase hex; radix 2..16
// (clamped), command code 3 is accepted and produces nothing
// a front end classifies each number and queues it two deep, so input words are
// taken while the back end is still busy with an earlier number
// back end per number: dequeue, then digit extraction, then one character per
// cycle while the receiver takes them; extraction is one digit per cycle for radix
// 2, 4, 8 and 16, and for other radices one pass per digit through the
// eight-bit-per-cycle long division unit, shortened while the quotient fits in 32 bits
// after the last digit is found the back end enters its emit state and then
// registers the first character into the output word
// the output word sits in a register; when the receiver stalls it holds and
// the back end waits, while the queue keeps taking input until it is full
// reset clears the queue, the back end state and the output valid
module integer_to_ascii_radix_formatter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// value[63:0], radix[68:64], uppercase[69], plus_sign[70], space_sign[71],
	// prefix_kind[73:72], zero fill above
	input  logic [ifr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// cmd[1:0]
	input  logic [ifr_pkg::CMD_W-1:0]       s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// char_out[7:0], char_count[13:8], zero fill above
	output logic [ifr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	output logic                            m_axis_tlast
);

	ifr_pkg::job_t                   push_job;
	ifr_pkg::job_t                   pop_job;
	logic                            push;
	logic                            pop;
	logic                            full;
	logic                            empty;
	logic [ifr_pkg::CHAR_W-1:0]      out_char;
	logic [ifr_pkg::COUNT_W-1:0]     out_count;

	// classify the incoming word
	ifr_front u_front (
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.cmd         (s_axis_tuser),
		.value       (s_axis_tdata[63:0]),
		.radix       (s_axis_tdata[68:64]),
		.uppercase   (s_axis_tdata[69]),
		.plus_sign   (s_axis_tdata[70]),
		.space_sign  (s_axis_tdata[71]),
		.prefix_kind (s_axis_tdata[73:72]),
		.full        (full),
		.push        (push),
		.job         (push_job)
	);

	// decouples front and back
	ifr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.pop       (pop),
		.pop_data  (pop_job),
		.full      (full),
		.empty     (empty)
	);

	// digit extraction and character emission
	ifr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop       (pop),
		.job       (pop_job),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_last  (m_axis_tlast),
		.out_count (out_count)
	);

	assign m_axis_tdata = {{(ifr_pkg::M_TDATA_W - ifr_pkg::COUNT_W - ifr_pkg::CHAR_W){1'b0}},
		out_count, out_char};

endmodule

[hdl/ifr_front.sv]
// front end: accepts a number and classifies it into sign/prefix, magnitude and radix
module ifr_front (
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ifr_pkg::CMD_W-1:0]     cmd,
	input  logic [ifr_pkg::MAG_W-1:0]     value,
	input  logic [ifr_pkg::RADIX_W-1:0]   radix,
	input  logic                          uppercase,
	input  logic                          plus_sign,
	input  logic                          space_sign,
	input  logic [ifr_pkg::PFX_W-1:0]     prefix_kind,
	input  logic                          full,
	output logic                          push,
	output ifr_pkg::job_t                 job
);

	logic [ifr_pkg::RADIX_W-1:0] radix_c;
	logic                        pow2_c;
	logic [ifr_pkg::LG2_W-1:0]   lg2_c;
	logic [ifr_pkg::HALF_W-1:0]  w32;
	logic [ifr_pkg::HALF_W-1:0]  neg32;
	logic                        known;

	always_comb begin
		if (radix < ifr_pkg::RADIX_MIN)
			radix_c = ifr_pkg::RADIX_MIN;
		else if (radix > ifr_pkg::RADIX_MAX)
			radix_c = ifr_pkg::RADIX_MAX;
		else
			radix_c = radix;

		unique case (radix_c)
			5'd2: begin
				pow2_c = 1'b1;
				lg2_c  = 2'd0;
			end
			5'd4: begin
				pow2_c = 1'b1;
				lg2_c  = 2'd1;
			end
			5'd8: begin
				pow2_c = 1'b1;
				lg2_c  = 2'd2;
			end
			5'd16: begin
				pow2_c = 1'b1;
				lg2_c  = 2'd3;
			end
			default: begin
				pow2_c = 1'b0;
				lg2_c  = 2'd0;
			end
		endcase
	end

	assign w32   = value[ifr_pkg::HALF_W-1:0];
	assign neg32 = ~w32 + 32'd1;

	always_comb begin
		job.mag   = {{ifr_pkg::HALF_W{1'b0}}, w32};
		job.radix = radix_c;
		job.pow2  = pow2_c;
		job.lg2   = lg2_c;
		job.upper = uppercase;
		job.npre  = 2'd0;
		job.pre0  = ifr_pkg::CH_ZERO;
		job.pre1  = ifr_pkg::CH_X_LO;
		known     = 1'b1;
		unique case (cmd)
			ifr_pkg::CMD_SIGNED: begin
				if (w32[ifr_pkg::HALF_W-1]) begin
					// two's complement negate also covers the most negative value
					job.mag  = {{ifr_pkg::HALF_W{1'b0}}, neg32};
					job.npre = 2'd1;
					job.pre0 = ifr_pkg::CH_MINUS;
				end else if (plus_sign) begin
					job.npre = 2'd1;
					job.pre0 = ifr_pkg::CH_PLUS;
				end else if (space_sign) begin
					job.npre = 2'd1;
					job.pre0 = ifr_pkg::CH_SPACE;
				end
			end
			ifr_pkg::CMD_UNSIGNED: begin
				if (prefix_kind == ifr_pkg::PFX_LOWER) begin
					job.npre = 2'd2;
					job.pre1 = ifr_pkg::CH_X_LO;
				end else if (prefix_kind == ifr_pkg::PFX_UPPER) begin
					job.npre = 2'd2;
					job.pre1 = ifr_pkg::CH_X_UP;
				end
			end
			ifr_pkg::CMD_ADDR: begin
				job.mag   = value;
				job.radix = ifr_pkg::RADIX_MAX;
				job.pow2  = 1'b1;
				job.lg2   = 2'd3;
				job.upper = 1'b0;
				job.npre  = 2'd2;
				job.pre1  = ifr_pkg::CH_X_LO;
			end
			default: begin
				// unused command: taken and dropped
				known = 1'b0;
			end
		endcase
	end

	assign in_ready = !full;
	assign push     = in_valid && !full && known;

endmodule

[hdl/ifr_fifo.sv]
// short queue of classified numbers between front and back
module ifr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ifr_pkg::job_t push_data,
	input  logic          pop,
	output ifr_pkg::job_t pop_data,
	output logic          full,
	output logic          empty
);

	ifr_pkg::job_t                  mem_q [ifr_pkg::FIFO_DEPTH];
	logic [ifr_pkg::FIFO_PTR_W-1:0] wr_q;
	logic [ifr_pkg::FIFO_PTR_W-1:0] rd_q;
	logic [ifr_pkg::FIFO_CNT_W-1:0] cnt_q;

	assign full     = cnt_q == ifr_pkg::FIFO_CNT_W'(ifr_pkg::FIFO_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

[hdl/ifr_digit.sv]
// digit extraction unit: shifts out power-of-two digits, long-divides by other radices
module ifr_digit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ifr_pkg::job_t job,
	output ifr_pkg::digit_t dig
);

	logic                              busy_q;
	logic                              inpass_q;
	logic [ifr_pkg::CHUNK_CNT_W-1:0]   cnt_q;
	logic [ifr_pkg::MAG_W-1:0]         work_q;
	logic [ifr_pkg::DIGIT_W-1:0]       rem_q;
	logic [ifr_pkg::RADIX_W-1:0]       radix_q;
	logic                              pow2_q;
	logic [ifr_pkg::LG2_W-1:0]         lg2_q;

	logic                              short_c;
	logic [ifr_pkg::MAG_W-1:0]         w_in;
	logic [ifr_pkg::DIGIT_W-1:0]       r_out;
	logic [ifr_pkg::CHUNK_BITS-1:0]    q_bits;
	logic [ifr_pkg::MAG_W-1:0]         w_div;
	logic [ifr_pkg::MAG_W-1:0]         w_sh;
	logic [ifr_pkg::MAG_W-1:0]         w_next;
	logic [ifr_pkg::DIGIT_W-1:0]       mask;

	// a quotient that fits in the low half needs only half a pass
	assign short_c = work_q[ifr_pkg::MAG_W-1:ifr_pkg::HALF_W] == '0;
	assign w_in    = (!inpass_q && short_c) ?
		{work_q[ifr_pkg::HALF_W-1:0], {ifr_pkg::HALF_W{1'b0}}} : work_q;

	// eight restoring division steps on a narrow remainder
	always_comb begin
		logic [ifr_pkg::DIGIT_W-1:0] r;
		logic [ifr_pkg::RADIX_W-1:0] t;
		r = inpass_q ? rem_q : '0;
		q_bits = '0;
		for (int i = 0; i < ifr_pkg::CHUNK_BITS; i++) begin
			t = {r, w_in[ifr_pkg::MAG_W-1-i]};
			if (t >= radix_q) begin
				q_bits[ifr_pkg::CHUNK_BITS-1-i] = 1'b1;
				r = ifr_pkg::DIGIT_W'(t - radix_q);
			end else begin
				r = t[ifr_pkg::DIGIT_W-1:0];
			end
		end
		r_out = r;
	end

	assign w_div = {w_in[ifr_pkg::MAG_W-ifr_pkg::CHUNK_BITS-1:0], q_bits};
	assign mask  = ifr_pkg::DIGIT_W'(radix_q - 5'd1);

	always_comb begin
		case (lg2_q)
			2'd0:    w_sh = work_q >> 1;
			2'd1:    w_sh = work_q >> 2;
			2'd2:    w_sh = work_q >> 3;
			default: w_sh = work_q >> 4;
		endcase
	end

	assign w_next    = pow2_q ? w_sh : w_div;
	assign dig.valid = busy_q && (pow2_q || (inpass_q && cnt_q == 3'd1));
	assign dig.value = pow2_q ? (work_q[ifr_pkg::DIGIT_W-1:0] & mask) : r_out;
	assign dig.last  = dig.valid && (w_next == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			inpass_q <= 1'b0;
			cnt_q    <= '0;
		end else if (start) begin
			busy_q   <= 1'b1;
			inpass_q <= 1'b0;
		end else if (busy_q) begin
			if (pow2_q) begin
				if (dig.last)
					busy_q <= 1'b0;
			end else if (!inpass_q) begin
				inpass_q <= 1'b1;
				cnt_q    <= short_c ? 3'd3 : 3'd7;
			end else if (cnt_q == 3'd1) begin
				inpass_q <= 1'b0;
				if (dig.last)
					busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q  <= job.mag;
			radix_q <= job.radix;
			pow2_q  <= job.pow2;
			lg2_q   <= job.lg2;
		end else if (busy_q) begin
			work_q <= w_next;
			rem_q  <= r_out;
		end
	end

endmodule

[hdl/ifr_back.sv]
// back end: collects digits, then emits prefix and digits most significant first
module ifr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	output logic                          pop,
	input  ifr_pkg::job_t                 job,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ifr_pkg::CHAR_W-1:0]    out_char,
	output logic                          out_last,
	output logic [ifr_pkg::COUNT_W-1:0]   out_count
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_DIGIT = 3'b010,
		ST_EMIT  = 3'b100
	} back_state_t;

	back_state_t                     state_q;
	ifr_pkg::job_t                   job_q;
	logic [ifr_pkg::DIGIT_W-1:0]     buf_q [ifr_pkg::MAX_DIGITS];
	logic [ifr_pkg::NDIG_W-1:0]      ndig_q;
	logic [ifr_pkg::DIG_IDX_W-1:0]   rd_q;
	logic [ifr_pkg::COUNT_W-1:0]     cnt_q;
	logic [ifr_pkg::COUNT_W-1:0]     total_q;
	logic                            ov_q;
	logic [ifr_pkg::CHAR_W-1:0]      ochar_q;
	logic                            olast_q;
	logic [ifr_pkg::COUNT_W-1:0]     ocount_q;

	ifr_pkg::digit_t                 dig;
	logic                            ld;
	logic                            emit;
	logic                            in_pre;
	logic [ifr_pkg::CHAR_W-1:0]      ch;
	logic [ifr_pkg::COUNT_W-1:0]     cnt_next;
	logic                            is_last;

	ifr_digit u_digit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pop),
		.job    (job),
		.dig    (dig)
	);

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign ld       = !ov_q || out_ready;
	assign emit     = (state_q == ST_EMIT) && ld;
	assign in_pre   = cnt_q < {4'd0, job_q.npre};
	assign cnt_next = cnt_q + 6'd1;
	assign is_last  = cnt_next == total_q;

	always_comb begin
		if (in_pre)
			ch = (cnt_q == '0) ? job_q.pre0 : job_q.pre1;
		else
			ch = ifr_pkg::digit_char(buf_q[rd_q], job_q.upper);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ndig_q  <= '0;
			rd_q    <= '0;
			cnt_q   <= '0;
			total_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						ndig_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (dig.valid) begin
						ndig_q <= ndig_q + 6'd1;
						if (dig.last) begin
							rd_q    <= ndig_q[ifr_pkg::DIG_IDX_W-1:0];
							total_q <= ndig_q + 6'd1 + {4'd0, job_q.npre};
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (emit) begin
						cnt_q <= cnt_next;
						if (!in_pre)
							rd_q <= rd_q - 5'd1;
						if (is_last)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (ld)
				ov_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= job;
		if (state_q == ST_DIGIT && dig.valid)
			buf_q[ndig_q[ifr_pkg::DIG_IDX_W-1:0]] <= dig.value;
		if (emit) begin
			ochar_q  <= ch;
			olast_q  <= is_last;
			ocount_q <= cnt_next;
		end
	end

	assign out_valid = ov_q;
	assign out_char  = ochar_q;
	assign out_last  = olast_q;
	assign out_count = ocount_q;

endmodule

[hdl/ifr_checker.sv]
// port-level checker for the formatter, bound to the top level
module ifr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [ifr_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tlast
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// character count stays within one to thirty-four
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[13:8] != 6'd0) && (m_axis_tdata[13:8] <= 6'd34))
		else $error("character count out of range");

	// within one number the count steps by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
			m_axis_tdata[13:8] == $past(m_axis_tdata[13:8], 1) + 6'd1)
		else $error("character count did not advance by one");

	// a new number restarts the count
	a_count_restart: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast ##1 m_axis_tvalid |->
			m_axis_tdata[13:8] == 6'd1)
		else $error("first character of a number does not have count one");

endmodule

bind integer_to_ascii_radix_formatter_core ifr_checker u_ifr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

[tb/ascii_text_checker.sv]
// watches both stream channels of the formatter, predicts each number's text and compares
module ascii_text_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [ifr_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input  logic [ifr_pkg::CMD_W-1:0]     s_axis_tuser,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [ifr_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input  logic                          m_axis_tlast,
	output int                            mismatch_count,
	output int                            pending_chars,
	output int                            chars_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ifr_pkg::CHAR_W-1:0]  ch;
		logic                        last;
		logic [ifr_pkg::COUNT_W-1:0] count;
	} text_char_t;

	text_char_t expected_chars[$];
	text_char_t oldest;

	initial begin
		mismatch_count = 0;
		pending_chars = 0;
		chars_checked = 0;
	end

	task automatic report_char_mismatch(input string what);
		mismatch_count++;
		$display("%0t ns: character mismatch: %s", $time, what);
	endtask

	// expected text of one number, queued with running count and end mark
	function automatic void predict_text(input logic [ifr_pkg::CMD_W-1:0] cmd,
			input logic [63:0] value, input logic [ifr_pkg::RADIX_W-1:0] radix_in,
			input logic upper, input logic plus, input logic space,
			input logic [ifr_pkg::PFX_W-1:0] pfx);
		logic [ifr_pkg::CHAR_W-1:0] text[$];
		logic [ifr_pkg::CHAR_W-1:0] digits[$];
		logic [63:0] mag;
		logic upper_eff;
		int base;
		int d;
		base = (radix_in < ifr_pkg::RADIX_MIN) ? 2 :
			((radix_in > ifr_pkg::RADIX_MAX) ? 16 : int'(radix_in));
		upper_eff = upper;
		mag = '0;
		case (cmd)
			ifr_pkg::CMD_SIGNED: begin
				if (value[31]) begin
					text.push_back(ifr_pkg::CH_MINUS);
					// two's complement magnitude; the most negative value stays 2^31
					mag[31:0] = ~value[31:0] + 32'd1;
				end else begin
					if (plus)
						text.push_back(ifr_pkg::CH_PLUS);
					else if (space)
						text.push_back(ifr_pkg::CH_SPACE);
					mag[31:0] = value[31:0];
				end
			end
			ifr_pkg::CMD_UNSIGNED: begin
				if (pfx == ifr_pkg::PFX_LOWER || pfx == ifr_pkg::PFX_UPPER) begin
					text.push_back(ifr_pkg::CH_ZERO);
					text.push_back(pfx == ifr_pkg::PFX_LOWER ?
						ifr_pkg::CH_X_LO : ifr_pkg::CH_X_UP);
				end
				mag[31:0] = value[31:0];
			end
			ifr_pkg::CMD_ADDR: begin
				text.push_back(ifr_pkg::CH_ZERO);
				text.push_back(ifr_pkg::CH_X_LO);
				mag = value;
				base = 16;
				upper_eff = 1'b0;
			end
			default: return;
		endcase
		do begin
			d = int'(mag % base);
			if (d < 10)
				digits.push_front(ifr_pkg::CH_ZERO + ifr_pkg::CHAR_W'(d));
			else
				digits.push_front((upper_eff ? ifr_pkg::CH_A_UP : ifr_pkg::CH_A_LO) +
					ifr_pkg::CHAR_W'(d - 10));
			mag = mag / base;
		end while (mag != 0);
		text = {text, digits};
		foreach (text[i])
			expected_chars.push_back('{text[i], i == text.size() - 1,
				ifr_pkg::COUNT_W'(i + 1)});
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				chars_checked++;
				if (expected_chars.size() == 0) begin
					report_char_mismatch($sformatf("unexpected word 0x%02h last %0d",
						m_axis_tdata[ifr_pkg::CHAR_W-1:0], m_axis_tlast));
				end else begin
					oldest = expected_chars.pop_front();
					if (m_axis_tdata[ifr_pkg::CHAR_W-1:0] !== oldest.ch)
						report_char_mismatch($sformatf("char_out 0x%02h, expected 0x%02h",
							m_axis_tdata[ifr_pkg::CHAR_W-1:0], oldest.ch));
					if (m_axis_tlast !== oldest.last)
						report_char_mismatch($sformatf("tlast %0d, expected %0d",
							m_axis_tlast, oldest.last));
					if (m_axis_tdata[ifr_pkg::CHAR_W+ifr_pkg::COUNT_W-1:ifr_pkg::CHAR_W] !==
							oldest.count)
						report_char_mismatch($sformatf("char_count %0d, expected %0d",
							m_axis_tdata[ifr_pkg::CHAR_W+ifr_pkg::COUNT_W-1:ifr_pkg::CHAR_W],
							oldest.count));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_text(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[68:64],
					s_axis_tdata[69], s_axis_tdata[70], s_axis_tdata[71], s_axis_tdata[73:72]);
			pending_chars = expected_chars.size();
		end
	end

endmodule

[tb/tb_integer_to_ascii_radix_formatter_core.sv]
// stimulus, clocking and verdict for the integer to ascii radix formatter testbench
module tb_integer_to_ascii_radix_formatter_core;
	timeunit 1ns;
	timeprecision 1ps;

	// codes the package leaves unnamed: unused command and unused prefix
	localparam logic [ifr_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
	localparam logic [ifr_pkg::PFX_W-1:0] PFX_RSVD = 2'd3;

	localparam int STALL_LIMIT     = 4000;  // cycles with no word moving on either side
	localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off, fills the queue
	localparam int DRAIN_CYCLES    = 200;   // quiet time after the last expected word
	localparam int PHASE_ITEMS     = 19;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [ifr_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [ifr_pkg::CMD_W-1:0]     s_axis_tuser = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [ifr_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic                          m_axis_tlast;

	int mismatch_count;
	int pending_chars;
	int chars_checked;
	int numbers_sent = 0;
	int quiet_cycles = 0;

	// idling mix of the current phase, in percent of cycles
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	// long hold-off request from stimulus, served once by the receiver process
	logic hold_off_req = 1'b0;
	logic hold_off_done = 1'b0;

	int mix_idle[4]  = '{0, 47, 0, 38};
	int mix_stall[4] = '{0, 0, 47, 38};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	integer_to_ascii_radix_formatter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	ascii_text_checker text_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.mismatch_count (mismatch_count),
		.pending_chars  (pending_chars),
		.chars_checked  (chars_checked)
	);

	// receiver: random stalls, plus one long hold-off counted here
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_off_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
				hold_off_done = 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// watchdog: ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d quiet cycles, %0d characters outstanding",
				quiet_cycles, pending_chars);
			$display("Mismatches found");
			$finish;
		end
	end

	// offers one number word, with random idle cycles ahead of it, and waits for
	// the handshake; tvalid stays high into the next word unless that one idles
	task automatic send_number(input logic [ifr_pkg::CMD_W-1:0] cmd, input logic [63:0] value,
			input logic [ifr_pkg::RADIX_W-1:0] radix, input logic upper, input logic plus,
			input logic space, input logic [ifr_pkg::PFX_W-1:0] pfx);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, pfx, space, plus, upper, radix, value};
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		numbers_sent++;
	endtask

	// random number word: mostly valid modes and radices, some unused codes and
	// out-of-range radices so every field bit toggles
	task automatic send_random_number();
		logic [ifr_pkg::CMD_W-1:0]   cmd;
		logic [63:0]                 value;
		logic [ifr_pkg::RADIX_W-1:0] radix;
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			cmd = ifr_pkg::CMD_SIGNED;
		else if (pick < 75)
			cmd = ifr_pkg::CMD_UNSIGNED;
		else if (pick < 93)
			cmd = ifr_pkg::CMD_ADDR;
		else
			cmd = CMD_NONE;
		case ($urandom_range(7))
			0: value = '0;
			1: value = 64'($urandom_range(40));
			2: value = {$urandom, 32'h8000_0000};          // most negative signed
			3: value = {$urandom, $urandom};
			default: value = {$urandom, $urandom} >> $urandom_range(63);
		endcase
		if ($urandom_range(9) < 8)
			radix = ifr_pkg::RADIX_W'($urandom_range(16, 2));
		else
			radix = ifr_pkg::RADIX_W'($urandom_range(31, 0));
		send_number(cmd, value, radix, 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)), ifr_pkg::PFX_W'($urandom_range(3)));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every mode, sign and prefix cases, clamping
		send_number(ifr_pkg::CMD_SIGNED, 64'd0, 5'd10, 1'b0, 1'b0, 1'b0, ifr_pkg::PFX_NONE);
		send_number(ifr_pkg::CMD_SIGNED, 64'h0000_0000_7FFF_FFFF, 5'd10, 1'b0, 1'b1, 1'b0,
			ifr_pkg::PFX_NONE);
		send_number(ifr_pkg::CMD_SIGNED, 64'hFFFF_FFFF_8000_0000, 5'd10, 1'b0, 1'b1, 1'b1,
			ifr_pkg::PFX_NONE);
		send_number(ifr_pkg::CMD_SIGNED, 64'h0000_0000_8000_0000, 5'd2, 1'b0, 1'b0, 1'b0,
			ifr_pkg::PFX_NONE);
		send_number(ifr_pkg::CMD_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 1'b1, 1'b0, 1'b0,
			ifr_pkg::PFX_LOWER);
		send_number(ifr_pkg::CMD_SIGNED, 64'd5, 5'd10, 1'b0, 1'b0, 1'b1, ifr_pkg::PFX_NONE);
		send_number(ifr_pkg::CMD_SIGNED, 64'd5, 5'd2, 1'b0, 1'b1, 1'b1, ifr_pkg::PFX_NONE);
		send_number(ifr_pkg::CMD_SIGNED, -64'sd123, 5'd7, 1'b1, 1'b1, 1'b0, ifr_pkg::PFX_NONE);
		send_number(ifr_pkg::CMD_UNSIGNED, 64'h0000_0000_FFFF_FFFF, 5'd2, 1'b0, 1'b0, 1'b0,
			ifr_pkg::PFX_LOWER);
		send_number(ifr_pkg::CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 1'b1, 1'b1, 1'b1,
			ifr_pkg::PFX_UPPER);
		send_number(ifr_pkg::CMD_UNSIGNED, 64'h1234_5678_00AB_CDEF, 5'd16, 1'b0, 1'b0, 1'b0,
			PFX_RSVD);
		send_number(ifr_pkg::CMD_UNSIGNED, 64'h0000_0000_FFFF_FFFF, 5'd3, 1'b0, 1'b0, 1'b0,
			ifr_pkg::PFX_NONE);
		send_number(ifr_pkg::CMD_UNSIGNED, 64'd12345, 5'd0, 1'b0, 1'b0, 1'b0,
			ifr_pkg::PFX_NONE);
		send_number(ifr_pkg::CMD_UNSIGNED, 64'd12345, 5'd1, 1'b0, 1'b0, 1'b0,
			ifr_pkg::PFX_LOWER);
		send_number(ifr_pkg::CMD_UNSIGNED, 64'd12345, 5'd17, 1'b1, 1'b0, 1'b0,
			ifr_pkg::PFX_NONE);
		send_number(ifr_pkg::CMD_UNSIGNED, 64'hDEAD_BEEF, 5'd31, 1'b0, 1'b0, 1'b0,
			ifr_pkg::PFX_UPPER);
		send_number(ifr_pkg::CMD_UNSIGNED, 64'd0, 5'd15, 1'b1, 1'b0, 1'b0, ifr_pkg::PFX_NONE);
		send_number(ifr_pkg::CMD_ADDR, 64'hFFFF_FFFF_FFFF_FFFF, 5'd10, 1'b1, 1'b1, 1'b1,
			ifr_pkg::PFX_UPPER);
		send_number(ifr_pkg::CMD_ADDR, 64'd0, 5'd31, 1'b0, 1'b0, 1'b0, ifr_pkg::PFX_NONE);
		send_number(ifr_pkg::CMD_ADDR, 64'hDEAD_BEEF_0123_4567, 5'd2, 1'b1, 1'b0, 1'b1,
			ifr_pkg::PFX_LOWER);
		send_number(CMD_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 1'b1, 1'b1, 1'b1, PFX_RSVD);
		send_number(ifr_pkg::CMD_SIGNED, 64'd42, 5'd10, 1'b0, 1'b0, 1'b0, ifr_pkg::PFX_NONE);

		// random phases under the four idling mixes
		for (int m = 0; m < 4; m++) begin
			sender_idle_pct = mix_idle[m];
			receiver_stall_pct = mix_stall[m];
			repeat (PHASE_ITEMS) send_random_number();
		end

		// back-pressure: receiver holds off while words keep coming, so the
		// queue fills and s_axis_tready drops
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_off_req = 1'b1;
		repeat (12) send_random_number();

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_chars != 0)
			@(posedge clk);
		// let any stray word show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d numbers: signed, unsigned, address and unused command,",
			numbers_sent);
		$display("clamped radix, all sign and prefix options; %0d characters compared, %s %0d",
			chars_checked, "incl. a hold-off of", HOLD_OFF_CYCLES);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
